[src/tmavg_pkg.sv]
// shared constants, types and helpers of the temperature averager
package tmavg_pkg;

  localparam int WINDOW     = 10;
  localparam int COUNT_BITS = 32;
  localparam int ADC_BITS   = 12;

  localparam int ADC_CODE_BITS = 12;
  localparam int OFFSET_BITS   = 20;
  localparam int SLOPE_BITS    = 16;
  localparam int TEMP_BITS     = 21;
  localparam int FILL_OUT_BITS = 4;
  localparam int FILL_OUT_MAX  = (1 << FILL_OUT_BITS) - 1;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 20;

  localparam int POS_BITS  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_BITS = $clog2(WINDOW + 1);
  localparam int WSUM_BITS = TEMP_BITS + POS_BITS;
  localparam int TSUM_BITS = TEMP_BITS + COUNT_BITS;

  localparam int PROD_BITS   = ADC_BITS + SLOPE_BITS;
  localparam int RND_SHIFT   = 8;
  localparam int ROUND_HALF  = 1 << (RND_SHIFT - 1);
  localparam int SCALED_BITS = PROD_BITS + 1 - RND_SHIFT;
  localparam int DIFF_BITS   = SCALED_BITS + 1;
  localparam int CCNT_BITS   = $clog2(ADC_BITS + 1);

  localparam int DIV_BITS  = TSUM_BITS;
  localparam int DCNT_BITS = $clog2(DIV_BITS);

  localparam int TEMP_MAX = (1 << (TEMP_BITS - 1)) - 1;
  localparam int TEMP_MIN = -(1 << (TEMP_BITS - 1));

  localparam logic signed [OFFSET_BITS-1:0] OFFSET_RESET = OFFSET_BITS'(111930);
  localparam logic [SLOPE_BITS-1:0]         SLOPE_RESET  = SLOPE_BITS'(30680);
  localparam logic [COUNT_BITS-1:0]         COUNT_MAX    = {COUNT_BITS{1'b1}};

  typedef logic signed [TEMP_BITS-1:0] temp_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_OFFSET = 2'd0,
    CFG_SLOPE  = 2'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CONV  = 4'b0010,
    ST_START = 4'b0100,
    ST_DIV   = 4'b1000
  } ctl_state_e;

  // window fill clipped to the width of the result field
  function automatic logic [FILL_OUT_BITS-1:0] sat_fill(input logic [FILL_BITS-1:0] f);
    if (int'(f) > FILL_OUT_MAX) begin
      return FILL_OUT_BITS'(FILL_OUT_MAX);
    end
    return FILL_OUT_BITS'(f);
  endfunction

endpackage

[src/tmavg_if.sv]
// handshake channels of the temperature averager: sample in, result out, config writes
interface tmavg_in_if import tmavg_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [ADC_CODE_BITS-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink (input valid, input adc_code, output ready);
endinterface

interface tmavg_out_if import tmavg_pkg::*;;
  logic                     valid;
  logic                     ready;
  temp_t                    sample_temp_q8;
  temp_t                    moving_avg_q8;
  temp_t                    running_avg_q8;
  logic [FILL_OUT_BITS-1:0] window_fill;
  logic                     count_saturated;

  modport source (output valid, output sample_temp_q8, output moving_avg_q8,
                  output running_avg_q8, output window_fill, output count_saturated,
                  input ready);
  modport sink (input valid, input sample_temp_q8, input moving_avg_q8,
                input running_avg_q8, input window_fill, input count_saturated,
                output ready);
endinterface

interface tmavg_cfg_if import tmavg_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[src/tmavg_conv.sv]
// bit-serial code to temperature conversion: shift-add multiply, round, offset, clamp
module tmavg_conv import tmavg_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ADC_BITS-1:0]           code_i,
  input  logic signed [OFFSET_BITS-1:0] offset_i,
  input  logic [SLOPE_BITS-1:0]         slope_i,
  output logic                          busy_o,
  output temp_t                         temp_o
);

  logic                        busy_q, busy_d;
  logic [CCNT_BITS-1:0]        cnt_q, cnt_d;
  logic [ADC_BITS-1:0]         code_q;
  logic [PROD_BITS-1:0]        acc_q, acc_step;
  temp_t                       temp_q, temp_sat;
  logic [PROD_BITS:0]          rnd;
  logic [SCALED_BITS-1:0]      scaled;
  logic signed [DIFF_BITS-1:0] diff;

  // msb first: shift the partial product and add the slope for each code bit
  assign acc_step = {acc_q[PROD_BITS-2:0], 1'b0}
                  + (code_q[ADC_BITS-1] ? PROD_BITS'(slope_i) : '0);

  assign rnd    = {1'b0, acc_q} + (PROD_BITS + 1)'(ROUND_HALF);
  assign scaled = rnd[PROD_BITS:RND_SHIFT];
  assign diff   = DIFF_BITS'(offset_i) - $signed({1'b0, scaled});

  always_comb begin
    if (diff > DIFF_BITS'(TEMP_MAX)) begin
      temp_sat = TEMP_BITS'(TEMP_MAX);
    end else if (diff < DIFF_BITS'(TEMP_MIN)) begin
      temp_sat = TEMP_BITS'(TEMP_MIN);
    end else begin
      temp_sat = diff[TEMP_BITS-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CCNT_BITS'(ADC_BITS);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      code_q <= code_i;
      acc_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        temp_q <= temp_sat;
      end else begin
        acc_q  <= acc_step;
        code_q <= {code_q[ADC_BITS-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign temp_o = temp_q;

endmodule

[src/tmavg_div.sv]
// restoring signed divider, one quotient bit per cycle, truncates toward zero
module tmavg_div import tmavg_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [DIV_BITS-1:0] dividend_i,
  input  logic [COUNT_BITS-1:0]      divisor_i,
  output logic                       busy_o,
  output temp_t                      quot_o
);

  logic                    busy_q, busy_d;
  logic [DCNT_BITS-1:0]    cnt_q, cnt_d;
  logic                    neg_q;
  logic [COUNT_BITS-1:0]   den_q;
  logic [COUNT_BITS-1:0]   rem_q;
  logic [DIV_BITS-1:0]     quo_q;
  logic [DIV_BITS-1:0]     mag;
  logic [COUNT_BITS:0]     rem_sh;
  logic [COUNT_BITS+1:0]   trial;
  logic                    fits;
  logic [TEMP_BITS-1:0]    quo_low;

  assign mag    = dividend_i[DIV_BITS-1] ? DIV_BITS'(-dividend_i) : DIV_BITS'(dividend_i);
  assign rem_sh = {rem_q, quo_q[DIV_BITS-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den_q};
  assign fits   = ~trial[COUNT_BITS+1];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DCNT_BITS'(DIV_BITS - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DIV_BITS-1];
      den_q <= divisor_i;
      rem_q <= '0;
      quo_q <= mag;
    end else if (busy_q) begin
      rem_q <= fits ? trial[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
      quo_q <= {quo_q[DIV_BITS-2:0], fits};
    end
  end

  // only the low bits of the quotient leave the block, so the sign fix is narrow
  assign quo_low = quo_q[TEMP_BITS-1:0];
  assign quot_o  = neg_q ? temp_t'(-quo_low) : temp_t'(quo_low);
  assign busy_o  = busy_q;

endmodule

[src/temperature_moving_and_running_average.sv]
// temperature averager top: config registers, window ring, totals, sequencer, output register
// the sequencer holds one sample at a time: the bit-serial multiplier and then the two restoring
// dividers run for each sample before the next sample is accepted
// a pending result may wait in the output register while the next sample is accepted
// reset: config registers take their defaults, window, sums and counts clear at once
module temperature_moving_and_running_average import tmavg_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  tmavg_cfg_if.sink   cfg_i,
  tmavg_in_if.sink    sample_i,
  tmavg_out_if.source result_o
);

  logic signed [OFFSET_BITS-1:0] offset_q;
  logic [SLOPE_BITS-1:0]         slope_q;

  ctl_state_e state_q, state_d;

  temp_t                       win_q [WINDOW];
  logic signed [WSUM_BITS-1:0] wsum_q, wsum_d;
  logic [POS_BITS-1:0]         wpos_q, wpos_d;
  logic [FILL_BITS-1:0]        fill_q, fill_d;
  logic signed [TSUM_BITS-1:0] tsum_q, tsum_d;
  logic [COUNT_BITS-1:0]       tcnt_q, tcnt_d;

  logic  in_acc, conv_busy, win_upd, div_start, div_done, out_load, count_full;
  logic  wdiv_busy, tdiv_busy;
  temp_t temp, mavg, ravg, old_temp;

  logic                     out_valid_q;
  temp_t                    out_temp_q, out_mavg_q, out_ravg_q;
  logic [FILL_OUT_BITS-1:0] out_fill_q;
  logic                     out_sat_q;

  // configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFFSET_RESET;
      slope_q  <= SLOPE_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_OFFSET: offset_q <= cfg_i.data[OFFSET_BITS-1:0];
        CFG_SLOPE:  slope_q  <= cfg_i.data[SLOPE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  assign sample_i.ready = (state_q == ST_IDLE);
  assign in_acc         = sample_i.valid && sample_i.ready;
  assign win_upd        = (state_q == ST_CONV) && !conv_busy;
  assign div_start      = (state_q == ST_START);
  assign div_done       = (state_q == ST_DIV) && !wdiv_busy && !tdiv_busy;
  assign out_load       = div_done && (!out_valid_q || result_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_CONV;
      ST_CONV:  if (!conv_busy) state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  tmavg_conv u_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc),
    .code_i   (sample_i.adc_code[ADC_BITS-1:0]),
    .offset_i (offset_q),
    .slope_i  (slope_q),
    .busy_o   (conv_busy),
    .temp_o   (temp)
  );

  // window ring and cumulative totals
  assign old_temp   = win_q[wpos_q];
  assign count_full = (tcnt_q == COUNT_MAX);

  always_comb begin
    wsum_d = wsum_q - WSUM_BITS'(old_temp) + WSUM_BITS'(temp);
    wpos_d = (wpos_q == POS_BITS'(WINDOW - 1)) ? '0 : wpos_q + 1'b1;
    fill_d = (fill_q == FILL_BITS'(WINDOW)) ? fill_q : fill_q + 1'b1;
    tsum_d = tsum_q;
    tcnt_d = tcnt_q;
    // once the count tops out the totals freeze
    if (!count_full) begin
      tsum_d = tsum_q + TSUM_BITS'(temp);
      tcnt_d = tcnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        win_q[i] <= '0;
      end
      wsum_q <= '0;
      wpos_q <= '0;
      fill_q <= '0;
      tsum_q <= '0;
      tcnt_q <= '0;
    end else if (win_upd) begin
      win_q[wpos_q] <= temp;
      wsum_q        <= wsum_d;
      wpos_q        <= wpos_d;
      fill_q        <= fill_d;
      tsum_q        <= tsum_d;
      tcnt_q        <= tcnt_d;
    end
  end

  tmavg_div u_wdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DIV_BITS'(wsum_q)),
    .divisor_i  (COUNT_BITS'(fill_q)),
    .busy_o     (wdiv_busy),
    .quot_o     (mavg)
  );

  tmavg_div u_tdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DIV_BITS'(tsum_q)),
    .divisor_i  (tcnt_q),
    .busy_o     (tdiv_busy),
    .quot_o     (ravg)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_temp_q <= temp;
      out_mavg_q <= mavg;
      out_ravg_q <= ravg;
      out_fill_q <= sat_fill(fill_q);
      out_sat_q  <= count_full;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.sample_temp_q8  = out_temp_q;
  assign result_o.moving_avg_q8   = out_mavg_q;
  assign result_o.running_avg_q8  = out_ravg_q;
  assign result_o.window_fill     = out_fill_q;
  assign result_o.count_saturated = out_sat_q;

endmodule
